// ----- sv/dtq_pkg.sv -----
// Package for the deadline timer queue: sizes, codes, beat structs and
// controller/datapath interface types. No dependencies.
`default_nettype none
package dtq_pkg;

	localparam int ENTRIES = 16;
	localparam int IW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(ENTRIES + 1);
	localparam int TW      = 63;
	localparam int ACT_W   = 5;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		op_t                opcode;
		logic        [31:0] owner_id;
		logic        [31:0] tmr_id;
		logic        [31:0] period;
		logic        [31:0] repeat_count;
		logic signed [31:0] elapsed;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               fired;
		logic        [31:0] fired_owner;
		logic        [31:0] fired_timer;
		logic [ACT_W-1:0]   active_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_TICK_CHK, S_SEARCH, S_SHIFT, S_INS_PREP, S_INSERT, S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    idx_inc;
		logic    idx_dec;
		logic    idx_load_cnt;
		logic    rd_prev;
		logic    shift_down;
		logic    shift_up;
		logic    write_new;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    head_take;
		logic    set_status;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic cnt_zero;
		logic idx_at_cnt;
		logic match;
		logic ins_here;
		logic head_due;
		logic rearm;
	} dp_sts_t;

	// Saturating time add, clamped at 2^63 - 1.
	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t, input logic [31:0] p);
		logic [TW:0] s;
		s = {1'b0, t} + {{(TW-31){1'b0}}, p};
		return s[TW] ? {TW{1'b1}} : s[TW-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- sv/deadline_timer_queue_unit.sv -----
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_ctrl, dtq_dp.
//
// Holds up to 16 timers sorted by deadline over a 63-bit saturating time.
// Issue a command beat with start while busy is low; busy stays high until
// the result beat, which is shown for exactly one cycle with done high and
// cannot be stalled, so sample response whenever done is seen. An unused
// opcode or a start on a full table goes straight to the result beat, as does
// a tick with nothing due. A start opens up the table from its end to the
// insert point; a stop searches and, on a match, closes up; a tick that
// fires closes up and, if it re-arms the head, opens up again to insert it.
// The walk is single-port over the cell table, one cell per cycle for search,
// close-up after a removal, and open-up for an insert. The next beat can be
// taken at the end of the cycle after the result beat.
// Write infinite_repeat_code on the cfg channel only while busy is low; it
// is always ready.
`default_nettype none
module deadline_timer_queue_unit
	import dtq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        request,
	output logic             done,
	output rsp_t             response,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// cfg_ready is tied high, so a register write is never stalled.
	assign cfg_ready = 1'b1;

	dtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	dtq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.response (response)
	);

endmodule
`default_nettype wire

// ----- sv/dtq_ctrl.sv -----
// Controller FSM for the deadline timer queue. Sequences the datapath walk.
// Depends on dtq_pkg.
`default_nettype none
module dtq_ctrl
	import dtq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	output logic         done,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = ST_OK;
		busy    = (state_q != S_IDLE);
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_START: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
							state_d        = S_DONE;
						end else begin
							cmd.idx_load_cnt = 1'b1;
							state_d          = S_INSERT;
						end
					end
					OP_STOP: state_d = S_SEARCH;
					OP_TICK: state_d = S_TICK_CHK;
					default: state_d = S_DONE;
				endcase
			end
			S_TICK_CHK: begin
				if (!sts.cnt_zero && sts.head_due) begin
					cmd.head_take = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = S_SHIFT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SEARCH: begin
				priority if (sts.idx_at_cnt) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
					state_d        = S_DONE;
				end else if (sts.match) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SHIFT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SHIFT: begin
				if (sts.idx_at_cnt) begin
					cmd.cnt_dec = 1'b1;
					state_d = (sts.op == OP_TICK && sts.rearm) ? S_INS_PREP : S_DONE;
				end else begin
					cmd.shift_down = 1'b1;
					cmd.idx_inc    = 1'b1;
				end
			end
			S_INS_PREP: begin
				cmd.idx_load_cnt = 1'b1;
				state_d          = S_INSERT;
			end
			S_INSERT: begin
				cmd.rd_prev = 1'b1;
				if (sts.ins_here) begin
					cmd.write_new = 1'b1;
					cmd.cnt_inc   = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.shift_up = 1'b1;
					cmd.idx_dec  = 1'b1;
				end
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/dtq_dp.sv -----
// Datapath for the deadline timer queue: sorted cell table, time, hold and
// result registers. Depends on dtq_pkg.
`default_nettype none
module dtq_dp
	import dtq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire req_t        request,
	input  wire logic        cfg_wr,
	input  wire logic [31:0] cfg_data,
	input  wire dp_cmd_t     cmd,
	output dp_sts_t          sts,
	output rsp_t             response
);

	logic [31:0]   cell_owner_q    [ENTRIES];
	logic [31:0]   cell_timer_q    [ENTRIES];
	logic [31:0]   cell_period_q   [ENTRIES];
	logic [31:0]   cell_repeat_q   [ENTRIES];
	logic [TW-1:0] cell_deadline_q [ENTRIES];

	logic [TW-1:0] time_q;
	logic [31:0]   irc_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	op_t           op_q;
	logic          rearm_q;
	logic [31:0]   hold_owner_q, hold_timer_q, hold_period_q, hold_repeat_q;
	logic [TW-1:0] hold_dl_q;
	status_t       res_status_q;
	logic          res_fired_q;
	logic [31:0]   res_owner_q, res_timer_q;

	logic [IW-1:0] idx_lo, idx_m1, rd;
	logic [31:0]   rd_owner, rd_timer, rd_period, rd_repeat, rd_rep_next;
	logic [TW-1:0] rd_dl, time_next;
	logic          el_pos;

	assign idx_lo = idx_q[IW-1:0];
	assign idx_m1 = idx_lo - IW'(1);
	assign rd     = cmd.rd_prev ? idx_m1 : idx_lo;

	assign rd_owner  = cell_owner_q[rd];
	assign rd_timer  = cell_timer_q[rd];
	assign rd_period = cell_period_q[rd];
	assign rd_repeat = cell_repeat_q[rd];
	assign rd_dl     = cell_deadline_q[rd];

	assign rd_rep_next = (rd_repeat != 32'd0 && rd_repeat != irc_q) ?
		rd_repeat - 32'd1 : rd_repeat;

	assign el_pos    = !request.elapsed[31] && (request.elapsed != 32'sd0);
	assign time_next = sat_add(time_q, request.elapsed[31:0]);

	always_comb begin
		sts.op         = op_q;
		sts.full       = (cnt_q == CW'(ENTRIES));
		sts.cnt_zero   = (cnt_q == '0);
		sts.idx_at_cnt = (idx_q == cnt_q);
		sts.match      = (rd_owner == hold_owner_q) && (rd_timer == hold_timer_q);
		sts.ins_here   = (idx_q == '0) || (rd_dl < hold_dl_q);
		sts.head_due   = (rd_dl <= time_q);
		sts.rearm      = rearm_q;
	end

	always_comb begin
		response.status       = res_status_q;
		response.fired        = res_fired_q;
		response.fired_owner  = res_owner_q;
		response.fired_timer  = res_timer_q;
		response.active_count = ACT_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			irc_q   <= '1;
			cnt_q   <= '0;
			idx_q   <= '0;
			op_q    <= OP_NONE;
			rearm_q <= 1'b0;
		end else begin
			if (cfg_wr) irc_q <= cfg_data;
			if (cmd.load) begin
				op_q    <= request.opcode;
				idx_q   <= '0;
				rearm_q <= 1'b0;
				if (request.opcode == OP_TICK && el_pos) time_q <= time_next;
			end
			if (cmd.idx_inc)      idx_q <= idx_q + CW'(1);
			if (cmd.idx_dec)      idx_q <= idx_q - CW'(1);
			if (cmd.idx_load_cnt) idx_q <= cnt_q;
			if (cmd.cnt_inc)      cnt_q <= cnt_q + CW'(1);
			if (cmd.cnt_dec)      cnt_q <= cnt_q - CW'(1);
			if (cmd.head_take)    rearm_q <= (rd_repeat != 32'd0);
		end
	end

	// Hold, result and cell payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hold_owner_q  <= request.owner_id;
			hold_timer_q  <= request.tmr_id;
			hold_period_q <= request.period;
			hold_repeat_q <= request.repeat_count;
			hold_dl_q     <= sat_add(time_q, request.period);
			res_status_q  <= ST_OK;
			res_fired_q   <= 1'b0;
			res_owner_q   <= '0;
			res_timer_q   <= '0;
		end
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.head_take) begin
			hold_owner_q  <= rd_owner;
			hold_timer_q  <= rd_timer;
			hold_period_q <= rd_period;
			hold_repeat_q <= rd_rep_next;
			hold_dl_q     <= sat_add(time_q, rd_period);
			res_fired_q   <= 1'b1;
			res_owner_q   <= rd_owner;
			res_timer_q   <= rd_timer;
		end
		if (cmd.shift_down) begin
			cell_owner_q[idx_m1]    <= rd_owner;
			cell_timer_q[idx_m1]    <= rd_timer;
			cell_period_q[idx_m1]   <= rd_period;
			cell_repeat_q[idx_m1]   <= rd_repeat;
			cell_deadline_q[idx_m1] <= rd_dl;
		end
		if (cmd.shift_up) begin
			cell_owner_q[idx_lo]    <= rd_owner;
			cell_timer_q[idx_lo]    <= rd_timer;
			cell_period_q[idx_lo]   <= rd_period;
			cell_repeat_q[idx_lo]   <= rd_repeat;
			cell_deadline_q[idx_lo] <= rd_dl;
		end
		if (cmd.write_new) begin
			cell_owner_q[idx_lo]    <= hold_owner_q;
			cell_timer_q[idx_lo]    <= hold_timer_q;
			cell_period_q[idx_lo]   <= hold_period_q;
			cell_repeat_q[idx_lo]   <= hold_repeat_q;
			cell_deadline_q[idx_lo] <= hold_dl_q;
		end
	end

endmodule
`default_nettype wire

// ----- sv/dtq_checker.sv -----
// Port-level checker for deadline_timer_queue_unit, bound to the top level.
// Depends on dtq_pkg.
`default_nettype none
module dtq_checker
	import dtq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t response
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise after accept");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat outside an item");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> response.active_count <= ACT_W'(ENTRIES))
		else $error("active count out of range");

	a_full_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		done && response.status == ST_FULL |-> !response.fired)
		else $error("full status with a firing");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.response (response)
);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for deadline_timer_queue_unit: a directed table of
// command beats, a fill to full, then random traffic, checked against a predictor.
// Depends on dtq_pkg and the deadline_timer_queue_unit RTL.
`default_nettype none
module testbench
	import dtq_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 1800;
	localparam logic [TW-1:0] TIME_SAT = {TW{1'b1}};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        request = '0;
	logic        done;
	rsp_t        response;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	deadline_timer_queue_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .response(response), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: the sorted timer table and the time base.
	typedef struct {
		logic [31:0]   owner;
		logic [31:0]   tid;
		logic [31:0]   period;
		logic [31:0]   rpt;
		logic [TW-1:0] deadline;
	} timer_t;

	timer_t        timers[$];
	logic [TW-1:0] now_time;
	logic [31:0]   forever_code;
	rsp_t          pending_rsp[$];
	int            fail_count = 0;
	int            cycle_count = 0;

	// Directed row: the command beat and, where obvious, the result it gives.
	typedef struct {
		req_t req;
		logic known;
		rsp_t rsp;
	} row_t;

	function automatic logic [TW-1:0] add_time(logic [TW-1:0] t, logic [31:0] p);
		logic [TW:0] s;
		s = {1'b0, t} + (TW+1)'(p);
		return s[TW] ? TIME_SAT : s[TW-1:0];
	endfunction

	// Place ahead of every timer with an equal or later deadline.
	function automatic void place_timer(timer_t t);
		int pos;
		pos = 0;
		while (pos < timers.size() && timers[pos].deadline < t.deadline)
			pos++;
		timers.insert(pos, t);
	endfunction

	function automatic rsp_t predict_result(req_t r);
		rsp_t   o;
		timer_t t;
		int     i;
		o = '0;
		case (r.opcode)
			OP_START: begin
				if (timers.size() >= ENTRIES) begin
					o.status = ST_FULL;
				end else begin
					t.owner = r.owner_id;
					t.tid = r.tmr_id;
					t.period = r.period;
					t.rpt = r.repeat_count;
					t.deadline = add_time(now_time, r.period);
					place_timer(t);
				end
			end
			OP_STOP: begin
				for (i = 0; i < timers.size(); i++)
					if (timers[i].owner == r.owner_id && timers[i].tid == r.tmr_id)
						break;
				if (i < timers.size())
					timers.delete(i);
				else
					o.status = ST_NOT_FOUND;
			end
			OP_TICK: begin
				if (r.elapsed > 0)
					now_time = add_time(now_time, r.elapsed);
				if (timers.size() > 0 && timers[0].deadline <= now_time) begin
					t = timers.pop_front();
					o.fired = 1'b1;
					o.fired_owner = t.owner;
					o.fired_timer = t.tid;
					if (t.rpt != 0) begin
						if (t.rpt != forever_code)
							t.rpt--;
						t.deadline = add_time(now_time, t.period);
						place_timer(t);
					end
				end
			end
			default: ;
		endcase
		o.active_count = ACT_W'(timers.size());
		return o;
	endfunction

	// Watchdog and result checking at the rising edge.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("deadline_timer_queue_unit regression: fail");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (response.status !== exp_rsp.status) begin
					$error("status exp %0d got %0d", exp_rsp.status, response.status);
					fail_count++;
				end
				if (response.fired !== exp_rsp.fired) begin
					$error("fired exp %0d got %0d", exp_rsp.fired, response.fired);
					fail_count++;
				end
				if (response.fired_owner !== exp_rsp.fired_owner) begin
					$error("fired_owner exp %h got %h", exp_rsp.fired_owner,
						response.fired_owner);
					fail_count++;
				end
				if (response.fired_timer !== exp_rsp.fired_timer) begin
					$error("fired_timer exp %h got %h", exp_rsp.fired_timer,
						response.fired_timer);
					fail_count++;
				end
				if (response.active_count !== exp_rsp.active_count) begin
					$error("active_count exp %0d got %0d", exp_rsp.active_count,
						response.active_count);
					fail_count++;
				end
			end
		end
	end

	// Send one command beat; the known result overrides the predicted one.
	task automatic send_command(req_t r, logic known, rsp_t given);
		rsp_t p;
		@(negedge clk);
		request <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = predict_result(r);
		pending_rsp.push_back(known ? given : p);
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic sender_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		repeat (n) @(negedge clk);
	endtask

	// Drain all results, then hold a little so the block is surely idle.
	task automatic wait_quiet();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4 * ENTRIES + 10) @(posedge clk);
	endtask

	task automatic write_forever_code(logic [31:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		forever_code = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t random_beat(int mode);
		req_t r;
		int   k;
		r.owner_id = $urandom_range(0, 3);
		r.tmr_id = $urandom_range(0, 3);
		if ($urandom_range(0, 9) == 0) begin
			r.owner_id = $urandom;
			r.tmr_id = $urandom;
		end
		r.period = $urandom_range(0, 40);
		k = $urandom_range(0, 19);
		if (k == 0) r.period = $urandom;
		else if (k == 1) r.period = 32'hFFFF_FFFF;
		r.repeat_count = $urandom_range(0, 3);
		k = $urandom_range(0, 9);
		if (k == 0) r.repeat_count = forever_code;
		else if (k == 1) r.repeat_count = $urandom;
		r.elapsed = $urandom_range(0, 20);
		k = $urandom_range(0, 19);
		if (k == 0) r.elapsed = $urandom;
		else if (k == 1) r.elapsed = -$urandom_range(1, 100);
		// Lean toward starts when sparse, toward stops when crowded.
		k = $urandom_range(0, 99);
		if (k < 2) r.opcode = OP_NONE;
		else if (k < 2 + mode) r.opcode = OP_START;
		else if (k < 70) r.opcode = OP_STOP;
		else r.opcode = OP_TICK;
		return r;
	endfunction

	initial begin
		row_t   plan[$];
		row_t   row;
		rsp_t   z;
		req_t   r;
		int     i;
		int     j;
		logic [31:0] codes[4];

		now_time = '0;
		forever_code = 32'hFFFF_FFFF;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		z = '0;
		// Empty table: stop misses, ticks fire nothing, unused opcode is inert.
		row.known = 1'b1;
		row.req = '{OP_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0};
		row.rsp = z; row.rsp.status = ST_NOT_FOUND; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, -32'sd1};
		row.rsp = z; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, 32'sh8000_0000};
		row.rsp = z; plan.push_back(row);
		row.req = '{OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'sh7FFF_FFFF};
		row.rsp = z; plan.push_back(row);
		// Zero period fires on the next tick even with zero elapsed.
		row.req = '{OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0};
		row.rsp = z; row.rsp.active_count = 1; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, 0};
		row.rsp = z; row.rsp.fired = 1'b1; row.rsp.fired_owner = 32'hFFFF_FFFF;
		row.rsp.fired_timer = 32'hFFFF_FFFF; plan.push_back(row);
		// Remaining rows: predictor checks ordering, equal deadlines and repeats.
		row.known = 1'b0;
		row.req = '{OP_START, 1, 1, 5, 2, 0}; plan.push_back(row);
		row.req = '{OP_START, 2, 2, 5, 32'hFFFF_FFFF, 0}; plan.push_back(row);
		row.req = '{OP_START, 3, 3, 32'hFFFF_FFFF, 0, 0}; plan.push_back(row);
		row.req = '{OP_STOP, 2, 1, 0, 0, 0}; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, 5}; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, 0}; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, 32'sh7FFF_FFFF}; plan.push_back(row);
		row.req = '{OP_TICK, 0, 0, 0, 0, 32'sh7FFF_FFFF}; plan.push_back(row);
		row.req = '{OP_STOP, 2, 2, 0, 0, 0}; plan.push_back(row);
		row.req = '{OP_STOP, 3, 3, 0, 0, 0}; plan.push_back(row);
		row.req = '{OP_STOP, 1, 1, 0, 0, 0}; plan.push_back(row);

		foreach (plan[i]) begin
			send_command(plan[i].req, plan[i].known, plan[i].rsp);
			sender_gap();
		end

		// Fill to the brim, then one more start must report full.
		for (i = 0; i <= ENTRIES; i++) begin
			r = '{OP_START, i, i, i * 3, 1, 0};
			send_command(r, 1'b0, z);
			sender_gap();
		end
		r = '{OP_TICK, 0, 0, 0, 0, 32'sh7FFF_FFFF};
		repeat (3 * ENTRIES) begin
			send_command(r, 1'b0, z);
			sender_gap();
		end
		// Hold off until every result is in, then advance time in large steps.
		wait_quiet();
		r = '{OP_TICK, 0, 0, 0, 0, 32'sh7FFF_FFFF};
		repeat (8) begin
			send_command(r, 1'b0, z);
			sender_gap();
		end

		// Random phases, each under its own forever code, extremes included.
		codes[0] = 32'h0000_0000;
		codes[1] = 32'h0000_0002;
		codes[2] = $urandom;
		codes[3] = 32'hFFFF_FFFF;
		for (j = 0; j < 4; j++) begin
			wait_quiet();
			write_forever_code(codes[j]);
			// Pick the opcode mix from how full the table is right now.
			for (i = 0; i < N_RANDOM / 4; i++) begin
				r = random_beat(timers.size() < ENTRIES / 2 ? 50 : 30);
				send_command(r, 1'b0, z);
				sender_gap();
			end
		end

		wait_quiet();
		if (fail_count == 0)
			$display("deadline_timer_queue_unit regression: pass");
		else
			$display("deadline_timer_queue_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
